FILE: rtl/nta_pkg.sv
// types, codes and control structs shared by the net track allocator modules
`default_nettype none

package nta_pkg;

    // request kinds
    localparam logic [1:0] REQ_ROUTE   = 2'd0;
    localparam logic [1:0] REQ_ANALYZE = 2'd1;
    localparam logic [1:0] REQ_CLEAR   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_TRACK = 2'd1;
    localparam logic [1:0] ST_NO_NET   = 2'd2;
    localparam logic [1:0] ST_NO_SLOT  = 2'd3;

    localparam int NET_W   = 8;
    localparam int COUNT_W = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [NET_W-1:0] net_id;
        logic             connect;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         track_index;
        logic               bank_half;
        logic [3:0]         x_line;
        logic [COUNT_W-1:0] ref_count;
        logic               track_freed;
        logic [2:0]         slot_index;
    } t_res;

    // one entry of the track memory
    typedef struct packed {
        logic [NET_W-1:0]   net;
        logic [COUNT_W-1:0] cnt;
    } t_trk;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TSCAN,
        ST_SSCAN,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       scan_init;
        logic       scan_step;
        logic       slot_mode;
        logic       trk_upd;
        logic       trk_rec;
        logic       slot_upd;
        logic       st_we;
        logic [1:0] st_code;
        logic       clear;
        logic       emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic done;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/nta_ram.sv
// generic single write port ram with registered read
`default_nettype none

module nta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic                 i_re,
    input  wire logic [AW-1:0]        i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/nta_ctrl.sv
// request sequencer: track scan, slot scan, update and result strobe
`default_nettype none

module nta_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [1:0]   i_req_type,
    input  wire nta_pkg::t_sts i_sts,
    output nta_pkg::t_cmd     o_cmd,
    output logic              o_busy
);

    nta_pkg::t_state r_state, n_state;
    logic [1:0]      r_kind, n_kind;
    nta_pkg::t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nta_pkg::ST_IDLE;
            r_kind  <= nta_pkg::REQ_ROUTE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_kind  = r_kind;
        case (r_state)
            nta_pkg::ST_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_kind   = i_req_type;
                    if (i_req_type == nta_pkg::REQ_ROUTE ||
                        i_req_type == nta_pkg::REQ_ANALYZE) begin
                        cmd.scan_init = 1'b1;
                        n_state       = nta_pkg::ST_TSCAN;
                    end else begin
                        n_state = nta_pkg::ST_DONE;
                    end
                end
            end
            nta_pkg::ST_TSCAN: begin
                if (i_sts.hit) begin
                    if (r_kind == nta_pkg::REQ_ROUTE) begin
                        cmd.trk_upd = 1'b1;
                        n_state     = nta_pkg::ST_DONE;
                    end else begin
                        // keep the track fields, then look for a slot
                        cmd.trk_rec   = 1'b1;
                        cmd.scan_init = 1'b1;
                        n_state       = nta_pkg::ST_SSCAN;
                    end
                end else if (i_sts.done) begin
                    cmd.st_we   = 1'b1;
                    cmd.st_code = (r_kind == nta_pkg::REQ_ROUTE) ?
                                  nta_pkg::ST_NO_TRACK : nta_pkg::ST_NO_NET;
                    n_state     = nta_pkg::ST_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            nta_pkg::ST_SSCAN: begin
                cmd.slot_mode = 1'b1;
                if (i_sts.hit) begin
                    cmd.slot_upd = 1'b1;
                    n_state      = nta_pkg::ST_DONE;
                end else if (i_sts.done) begin
                    cmd.st_we   = 1'b1;
                    cmd.st_code = nta_pkg::ST_NO_SLOT;
                    n_state     = nta_pkg::ST_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            nta_pkg::ST_DONE: begin
                cmd.emit  = 1'b1;
                cmd.clear = (r_kind == nta_pkg::REQ_CLEAR);
                n_state   = nta_pkg::ST_IDLE;
            end
            default: begin
                n_state = nta_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != nta_pkg::ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/nta_dp.sv
// datapath: used bits, track and slot memories, scan pipeline, result registers
`default_nettype none

module nta_dp #(
    parameter int MAIN_TRACKS    = 32,
    parameter int HALF_TRACKS    = 16,
    parameter int ANALYZER_SLOTS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire nta_pkg::t_req i_req,
    input  wire nta_pkg::t_cmd i_cmd,
    output nta_pkg::t_sts      o_sts,
    output logic               o_valid,
    output nta_pkg::t_res      o_res
);

    localparam int TW = $clog2(MAIN_TRACKS);
    localparam int SW = (ANALYZER_SLOTS > 1) ? $clog2(ANALYZER_SLOTS) : 1;
    localparam int XW = (HALF_TRACKS > 1) ? $clog2(HALF_TRACKS) : 1;
    localparam int IW = (TW > SW) ? TW : SW;
    localparam int CW = IW + 1;
    localparam int TRK_W = $bits(nta_pkg::t_trk);
    localparam logic [CW-1:0] TRK_LIMIT  = CW'(MAIN_TRACKS);
    localparam logic [CW-1:0] SLOT_LIMIT = CW'(ANALYZER_SLOTS);
    localparam logic [XW-1:0] X_LAST     = XW'(HALF_TRACKS - 1);

    nta_pkg::t_req r_req;
    logic          r_tused [MAIN_TRACKS];
    logic          r_sused [ANALYZER_SLOTS];

    // scan pipeline: read address stage, then compare stage
    logic [CW-1:0] r_rd;
    logic [XW-1:0] r_rx;
    logic          r_rb;
    logic          r_cvld;
    logic [IW-1:0] r_ci;
    logic [XW-1:0] r_cx;
    logic          r_cb;

    nta_pkg::t_res r_res;
    nta_pkg::t_res r_out;
    logic          r_valid;

    logic [CW-1:0]          limit;
    logic                   rd_ok;
    logic                   trk_re, slot_re;
    logic [TRK_W-1:0]       trk_rdata;
    nta_pkg::t_trk          trk_q;
    logic [nta_pkg::NET_W-1:0] slot_q;
    logic [TW-1:0]          t_addr;
    logic [SW-1:0]          s_addr;
    logic                   tused_c, sused_c;
    logic                   trk_match, slot_match;
    logic [nta_pkg::COUNT_W-1:0] cnt_eff, cnt_new;
    logic                   keep_used;
    nta_pkg::t_trk          trk_wdata;
    logic                   trk_we, slot_we;

    assign limit   = i_cmd.slot_mode ? SLOT_LIMIT : TRK_LIMIT;
    assign rd_ok   = (r_rd < limit);
    assign trk_re  = i_cmd.scan_step & rd_ok & ~i_cmd.slot_mode;
    assign slot_re = i_cmd.scan_step & rd_ok & i_cmd.slot_mode;
    assign t_addr  = r_ci[TW-1:0];
    assign s_addr  = r_ci[SW-1:0];
    assign trk_q   = nta_pkg::t_trk'(trk_rdata);
    assign tused_c = r_tused[t_addr];
    assign sused_c = r_sused[s_addr];

    always_comb begin
        if (r_req.req_type == nta_pkg::REQ_ROUTE) begin
            trk_match = ~tused_c | (trk_q.net == r_req.net_id);
        end else begin
            trk_match = tused_c & (trk_q.net == r_req.net_id);
        end
        if (r_req.connect) begin
            slot_match = ~sused_c;
        end else begin
            slot_match = sused_c & (slot_q == r_req.net_id);
        end
    end

    assign o_sts.hit  = r_cvld & (i_cmd.slot_mode ? slot_match : trk_match);
    assign o_sts.done = ~r_cvld & ~rd_ok;

    // a free track counts as zero whatever the memory holds
    always_comb begin
        cnt_eff   = tused_c ? trk_q.cnt : '0;
        keep_used = 1'b1;
        if (r_req.connect) begin
            cnt_new = (cnt_eff == nta_pkg::COUNT_MAX) ? cnt_eff : cnt_eff + 1'b1;
        end else if (cnt_eff <= nta_pkg::COUNT_W'(1)) begin
            cnt_new   = '0;
            keep_used = 1'b0;
        end else begin
            cnt_new = cnt_eff - 1'b1;
        end
        trk_wdata.net = r_req.net_id;
        trk_wdata.cnt = cnt_new;
    end

    assign trk_we  = i_cmd.trk_upd & keep_used;
    assign slot_we = i_cmd.slot_upd & r_req.connect;

    nta_ram #(
        .WIDTH (TRK_W),
        .DEPTH (MAIN_TRACKS)
    ) u_trk_ram (
        .i_clk   (i_clk),
        .i_we    (trk_we),
        .i_waddr (t_addr),
        .i_wdata (trk_wdata),
        .i_re    (trk_re),
        .i_raddr (r_rd[TW-1:0]),
        .o_rdata (trk_rdata)
    );

    nta_ram #(
        .WIDTH (nta_pkg::NET_W),
        .DEPTH (ANALYZER_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (s_addr),
        .i_wdata (r_req.net_id),
        .i_re    (slot_re),
        .i_raddr (r_rd[SW-1:0]),
        .o_rdata (slot_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    // used bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < MAIN_TRACKS; i++) begin
                r_tused[i] <= 1'b0;
            end
            for (int i = 0; i < ANALYZER_SLOTS; i++) begin
                r_sused[i] <= 1'b0;
            end
        end else begin
            if (i_cmd.trk_upd) begin
                r_tused[t_addr] <= keep_used;
            end
            if (i_cmd.slot_upd) begin
                r_sused[s_addr] <= r_req.connect;
            end
        end
    end

    // scan counters, x line and bank follow the index so no modulo is needed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd   <= '0;
            r_rx   <= '0;
            r_rb   <= 1'b0;
            r_cvld <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_rd   <= '0;
            r_rx   <= '0;
            r_rb   <= 1'b0;
            r_cvld <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_cvld <= rd_ok;
            if (rd_ok) begin
                r_rd <= r_rd + 1'b1;
                if (r_rx == X_LAST) begin
                    r_rx <= '0;
                    r_rb <= 1'b1;
                end else begin
                    r_rx <= r_rx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && rd_ok) begin
            r_ci <= r_rd[IW-1:0];
            r_cx <= r_rx;
            r_cb <= r_rb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res <= '0;
        end else begin
            if (i_cmd.trk_upd || i_cmd.trk_rec) begin
                r_res.track_index <= 5'(t_addr);
                r_res.bank_half   <= r_cb;
                r_res.x_line      <= 4'(r_cx);
            end
            if (i_cmd.trk_upd) begin
                r_res.ref_count   <= cnt_new;
                r_res.track_freed <= ~keep_used;
            end
            if (i_cmd.trk_rec) begin
                r_res.ref_count <= trk_q.cnt;
            end
            if (i_cmd.slot_upd) begin
                r_res.slot_index <= 3'(s_addr);
            end
            if (i_cmd.st_we) begin
                r_res.status <= i_cmd.st_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_out;

endmodule

`default_nettype wire

FILE: rtl/net_track_allocator.sv
// top level of the net track allocator: controller, datapath and checks
//
// A request is taken when start is high and busy is low; busy stays high
// until the request is finished, and its single result beat appears on
// o_res with o_valid high for exactly one cycle, which the receiver must
// take as it comes. The track table is searched one entry per cycle through
// the read port of the track memory, and the analyzer slots the same way
// through the slot memory. A route request stops at the first free or
// matching track, an analyzer request goes on to scan the slots once its
// net is found, and a clear goes straight to its result beat. No memory
// clearing pass is needed after reset.
`default_nettype none

module net_track_allocator #(
    parameter int MAIN_TRACKS    = 32,
    parameter int HALF_TRACKS    = 16,
    parameter int ANALYZER_SLOTS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire nta_pkg::t_req i_req,
    output logic               busy,
    output logic               o_valid,
    output nta_pkg::t_res      o_res
);

    nta_pkg::t_cmd cmd;
    nta_pkg::t_sts sts;

    nta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    nta_dp #(
        .MAIN_TRACKS    (MAIN_TRACKS),
        .HALF_TRACKS    (HALF_TRACKS),
        .ANALYZER_SLOTS (ANALYZER_SLOTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // a result beat never overlaps a request in flight
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beat longer than one cycle");

    // a route update always leads to its beat, through the done state and the valid register
    a_route_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.trk_upd |=> ##1 o_valid)
        else $error("route update without result beat");

    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.trk_upd, cmd.trk_rec, cmd.slot_upd, cmd.clear, cmd.load}))
        else $error("conflicting datapath updates");

endmodule

`default_nettype wire
